/* rtl/dpc_pkg.sv */
// dpc_pkg: shared constants, types and the CRC-32 byte update for the delta prefilter.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package dpc_pkg;

    localparam int LEN_W   = 32;   // length and position width
    localparam int OFF_W   = 32;   // output offset width
    localparam int VAL_W   = 32;
    localparam int NB_W    = 3;

    localparam logic [LEN_W-1:0] HEADER_BYTES = LEN_W'(48);

    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;

    // filter modes
    localparam logic [1:0] MODE_COPY    = 2'd0;
    localparam logic [1:0] MODE_DELTA16 = 2'd1;
    localparam logic [1:0] MODE_DELTA32 = 2'd2;
    localparam logic [1:0] MODE_DEINT16 = 2'd3;

    // configuration register indexes
    localparam logic CFG_IDX_MODE   = 1'b0;
    localparam logic CFG_IDX_LENGTH = 1'b1;

    // out_bytes codes
    localparam logic [NB_W-1:0] NB_NONE = 3'd0;
    localparam logic [NB_W-1:0] NB_ONE  = 3'd1;
    localparam logic [NB_W-1:0] NB_TWO  = 3'd2;
    localparam logic [NB_W-1:0] NB_FOUR = 3'd4;

    typedef struct packed {
        logic [VAL_W-1:0] out_value;
        logic [NB_W-1:0]  out_bytes;
        logic [OFF_W-1:0] out_offset;
        logic             data_valid;
        logic             done_res;
        logic [31:0]      crc_value;
        logic             length_error;
    } result_t;

    // reflected CRC-32, one byte, bitwise
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/delta_prefilter_with_crc32_top.sv */
// A result is registered and appears on the m_ channel in the cycle after its input byte transfer.
// One byte per cycle; s_ready falls only while a held result waits on m_ready.
// Bytes inside a word produce no result, so results come at most one per byte.
// Reset (aresetn low, synchronous): mode and length registers to 0, position and
// word state to 0, CRC to all ones, result register empty. No clearing pass.
// Depends on dpc_pkg.
`default_nettype none

module delta_prefilter_with_crc32_top
    import dpc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // configuration write channel
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_index,
    input  wire logic [31:0]       cfg_data,
    // byte input channel
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_in_byte,
    // result channel
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [VAL_W-1:0]       m_out_value,
    output logic [NB_W-1:0]        m_out_bytes,
    output logic [OFF_W-1:0]       m_out_offset,
    output logic                   m_data_valid,
    output logic                   m_done_res,
    output logic [31:0]            m_crc_value,
    output logic                   m_length_error
);

    // Configuration registers
    logic [1:0]       mode_reg;
    logic [LEN_W-1:0] length_reg;

    // Per-file stream state
    logic [LEN_W-1:0] pos_reg,       pos_next;
    logic [31:0]      word_reg,      word_next;
    logic [31:0]      prev_even_reg, prev_even_next;
    logic [15:0]      prev_odd_reg,  prev_odd_next;
    logic [31:0]      crc_reg,       crc_next;

    // Result register (acts as the output stage that decouples s_ and m_)
    logic             out_valid_reg;
    result_t          out_reg;
    result_t          res;
    logic             res_fire;

    logic             s_xfer;
    logic             last;
    logic             len_bad;
    logic             in_header;
    logic [LEN_W-1:0] rel;
    logic [LEN_W-1:0] len_rel;
    logic [1:0]       lane;
    logic [31:0]      word_asm;
    logic [LEN_W-1:0] pos_inc;

    // Config writes are always taken; software must only write while idle; the block does not enforce this.
    assign cfg_ready = 1'b1;

    // A new byte is taken whenever the result register is empty or draining.
    assign s_ready = !out_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;

    always_comb begin
        pos_inc   = pos_reg + LEN_W'(1);
        last      = (length_reg != '0) && (pos_inc == length_reg);
        len_rel   = length_reg - HEADER_BYTES;
        in_header = pos_reg < HEADER_BYTES;
        rel       = pos_reg - HEADER_BYTES;

        // length check: delta modes need whole words after the header
        unique case (mode_reg)
            MODE_COPY:    len_bad = 1'b0;
            MODE_DELTA16: len_bad = (length_reg < HEADER_BYTES) || len_rel[0];
            default:      len_bad = (length_reg < HEADER_BYTES) || (len_rel[1:0] != 2'd0);
        endcase

        lane     = (mode_reg == MODE_DELTA16) ? {1'b0, rel[0]} : rel[1:0];
        word_asm = (lane == 2'd0) ? {24'd0, s_in_byte}
                                  : (word_reg | ({24'd0, s_in_byte} << {lane, 3'b000}));

        crc_next       = crc_byte(crc_reg, s_in_byte);
        word_next      = word_reg;
        prev_even_next = prev_even_reg;
        prev_odd_next  = prev_odd_reg;

        res              = '0;

        if (!len_bad) begin
            if ((mode_reg == MODE_COPY) || in_header) begin
                res.data_valid = 1'b1;
                res.out_value  = {24'd0, s_in_byte};
                res.out_bytes  = NB_ONE;
                res.out_offset = OFF_W'(pos_reg);
            end else begin
                word_next = word_asm;
                if ((mode_reg == MODE_DELTA16) && (lane == 2'd1)) begin
                    res.data_valid = 1'b1;
                    res.out_value  = {16'd0, prev_even_reg[15:0] - word_asm[15:0]};
                    res.out_bytes  = NB_TWO;
                    res.out_offset = OFF_W'(pos_reg - LEN_W'(1));
                    prev_even_next = {16'd0, word_asm[15:0]};
                end else if ((mode_reg == MODE_DELTA32) && (lane == 2'd3)) begin
                    res.data_valid = 1'b1;
                    res.out_value  = prev_even_reg - word_asm;
                    res.out_bytes  = NB_FOUR;
                    res.out_offset = OFF_W'(pos_reg - LEN_W'(3));
                    prev_even_next = word_asm;
                end else if ((mode_reg == MODE_DEINT16) && (lane == 2'd1)) begin
                    // even words go into the first half of the filtered area
                    res.data_valid = 1'b1;
                    res.out_value  = {16'd0, prev_even_reg[15:0] - word_asm[15:0]};
                    res.out_bytes  = NB_TWO;
                    res.out_offset = OFF_W'(HEADER_BYTES + (rel >> 1));
                    prev_even_next = {16'd0, word_asm[15:0]};
                end else if ((mode_reg == MODE_DEINT16) && (lane == 2'd3)) begin
                    // odd words go after all even words
                    res.data_valid = 1'b1;
                    res.out_value  = {16'd0, prev_odd_reg - word_asm[31:16]};
                    res.out_bytes  = NB_TWO;
                    res.out_offset = OFF_W'(HEADER_BYTES + (len_rel >> 1)
                                            + {rel[LEN_W-1:2], 1'b0});
                    prev_odd_next  = word_asm[31:16];
                end
            end
        end

        if (last) begin
            res.done_res     = 1'b1;
            res.crc_value    = ~crc_next;
            res.length_error = len_bad;
        end

        res_fire = res.data_valid || last;

        // final byte puts the stream state back to its reset value
        pos_next = pos_inc;
        if (last) begin
            pos_next       = '0;
            word_next      = '0;
            prev_even_next = '0;
            prev_odd_next  = '0;
            crc_next       = CRC_PRESET;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_COPY;
            length_reg    <= '0;
            pos_reg       <= '0;
            word_reg      <= '0;
            prev_even_reg <= '0;
            prev_odd_reg  <= '0;
            crc_reg       <= CRC_PRESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_IDX_MODE:   mode_reg   <= cfg_data[1:0];
                    CFG_IDX_LENGTH: length_reg <= cfg_data[LEN_W-1:0];
                endcase
            end
            if (s_xfer) begin
                pos_reg       <= pos_next;
                word_reg      <= word_next;
                prev_even_reg <= prev_even_next;
                prev_odd_reg  <= prev_odd_next;
                crc_reg       <= crc_next;
                out_valid_reg <= res_fire;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload: loaded on every input transfer, held while stalled
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            out_reg <= res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_out_value    = out_reg.out_value;
    assign m_out_bytes    = out_reg.out_bytes;
    assign m_out_offset   = out_reg.out_offset;
    assign m_data_valid   = out_reg.data_valid;
    assign m_done_res     = out_reg.done_res;
    assign m_crc_value    = out_reg.crc_value;
    assign m_length_error = out_reg.length_error;

endmodule

`default_nettype wire

/* rtl/dpc_checker.sv */
// dpc_checker: port-level assertions for the delta prefilter, bound to its top level.
// Depends on dpc_pkg and delta_prefilter_with_crc32_top.
`default_nettype none

module dpc_checker
    import dpc_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [VAL_W-1:0]  m_out_value,
    input wire logic [NB_W-1:0]   m_out_bytes,
    input wire logic [OFF_W-1:0]  m_out_offset,
    input wire logic              m_data_valid,
    input wire logic              m_done_res,
    input wire logic [31:0]       m_crc_value,
    input wire logic              m_length_error
);

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a result without data must be the end-of-file result
    a_nodata_is_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data_valid) |-> m_done_res)
        else $error("empty result that is not done");

    // data results carry 1, 2 or 4 bytes; otherwise value fields are zero
    a_bytes_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data_valid ? (m_out_bytes == NB_ONE || m_out_bytes == NB_TWO
                                     || m_out_bytes == NB_FOUR)
                                  : (m_out_bytes == NB_NONE && m_out_value == '0
                                     && m_out_offset == '0)))
        else $error("bad byte count or nonzero empty fields");

    // CRC and error flag only on the done result
    a_done_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_done_res) |-> (m_crc_value == '0 && !m_length_error))
        else $error("crc or error shown without done");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_value)
                                   && $stable(m_out_offset) && $stable(m_crc_value)))
        else $error("stalled result changed");

endmodule

bind delta_prefilter_with_crc32_top dpc_checker u_dpc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_out_value    (m_out_value),
    .m_out_bytes    (m_out_bytes),
    .m_out_offset   (m_out_offset),
    .m_data_valid   (m_data_valid),
    .m_done_res     (m_done_res),
    .m_crc_value    (m_crc_value),
    .m_length_error (m_length_error)
);

`default_nettype wire

/* test/delta_prefilter_with_crc32_top_tb.sv */
// Self-checking testbench for delta_prefilter_with_crc32_top: byte stream in, filtered words out.
// A tracker class predicts every result (CRC-32, delta chains, offsets, length errors).
// Depends on dpc_pkg and the top-level RTL only.

import dpc_pkg::*;

class filtered_stream_board;
    // predictor state, mirrors the block's registers
    logic [1:0]  mode;
    logic [31:0] file_len;
    logic [31:0] pos;
    logic [31:0] word_acc;
    logic [31:0] prev_even;
    logic [15:0] prev_odd;
    logic [31:0] crc;

    result_t     awaited_results[$];
    int          mismatches;
    int          data_results;
    int          files_closed;
    int          error_closes;

    function new();
        mode         = MODE_COPY;
        file_len     = '0;
        mismatches   = 0;
        data_results = 0;
        files_closed = 0;
        error_closes = 0;
        restart_file();
    endfunction

    function void restart_file();
        pos       = '0;
        word_acc  = '0;
        prev_even = '0;
        prev_odd  = '0;
        crc       = CRC_PRESET;
    endfunction

    function logic [31:0] crc32_update(logic [31:0] acc, logic [7:0] b);
        logic [31:0] c;
        c = acc;
        for (int i = 0; i < 8; i++) begin
            if (c[0] ^ b[i]) c = (c >> 1) ^ CRC_POLY;
            else c = c >> 1;
        end
        return c;
    endfunction

    function bit length_unsupported();
        logic [31:0] rest;
        if (mode == MODE_COPY) return 1'b0;
        if (file_len < HEADER_BYTES) return 1'b1;
        rest = file_len - HEADER_BYTES;
        if (mode == MODE_DELTA16) return rest[0];
        return rest[1:0] != 2'd0;
    endfunction

    function void set_reg(logic idx, logic [31:0] data);
        if (idx == CFG_IDX_MODE) mode = data[1:0];
        else file_len = data;
    endfunction

    function int outstanding();
        return awaited_results.size();
    endfunction

    // one byte transfer accepted on the input side
    function void note_byte(logic [7:0] b);
        result_t     r;
        bit          last;
        bit          bad;
        bit          dv;
        logic [31:0] rel;
        logic [1:0]  lane;
        r    = '0;
        dv   = 1'b0;
        last = (file_len != 0) && (pos + 32'd1 == file_len);
        bad  = length_unsupported();
        crc  = crc32_update(crc, b);
        if (!bad) begin
            if (mode == MODE_COPY || pos < HEADER_BYTES) begin
                dv           = 1'b1;
                r.out_value  = {24'd0, b};
                r.out_bytes  = NB_ONE;
                r.out_offset = pos;
            end else begin
                rel  = pos - HEADER_BYTES;
                lane = (mode == MODE_DELTA16) ? {1'b0, rel[0]} : rel[1:0];
                if (lane == 2'd0) word_acc = {24'd0, b};
                else word_acc = word_acc | ({24'd0, b} << (8 * lane));
                if (mode == MODE_DELTA16 && lane == 2'd1) begin
                    r.out_value  = {16'd0, prev_even[15:0] - word_acc[15:0]};
                    prev_even    = {16'd0, word_acc[15:0]};
                    r.out_bytes  = NB_TWO;
                    r.out_offset = pos - 32'd1;
                    dv           = 1'b1;
                end else if (mode == MODE_DELTA32 && lane == 2'd3) begin
                    r.out_value  = prev_even - word_acc;
                    prev_even    = word_acc;
                    r.out_bytes  = NB_FOUR;
                    r.out_offset = pos - 32'd3;
                    dv           = 1'b1;
                end else if (mode == MODE_DEINT16 && lane == 2'd1) begin
                    // even word: packed right after the header
                    r.out_value  = {16'd0, prev_even[15:0] - word_acc[15:0]};
                    prev_even    = {16'd0, word_acc[15:0]};
                    r.out_bytes  = NB_TWO;
                    r.out_offset = HEADER_BYTES + (rel >> 1);
                    dv           = 1'b1;
                end else if (mode == MODE_DEINT16 && lane == 2'd3) begin
                    // odd word: placed after all even words
                    r.out_value  = {16'd0, prev_odd - word_acc[31:16]};
                    prev_odd     = word_acc[31:16];
                    r.out_bytes  = NB_TWO;
                    r.out_offset = HEADER_BYTES + ((file_len - HEADER_BYTES) >> 1)
                                   + ((rel >> 2) << 1);
                    dv           = 1'b1;
                end
            end
        end
        if (!dv && !last) begin
            pos = pos + 32'd1;
            return;
        end
        r.data_valid = dv;
        if (last) begin
            r.done_res     = 1'b1;
            r.crc_value    = ~crc;
            r.length_error = bad;
            restart_file();
        end else begin
            pos = pos + 32'd1;
        end
        awaited_results = {awaited_results, r};
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", field, want, got);
            mismatches++;
        end
    endfunction

    // one result transfer accepted on the output side
    function void check_result(result_t got);
        result_t want;
        if (awaited_results.size() == 0) begin
            $error("result transfer with nothing expected: value %h offset %h done %b",
                   got.out_value, got.out_offset, got.done_res);
            mismatches++;
            return;
        end
        want = awaited_results.pop_front();
        compare("out_value", want.out_value, got.out_value);
        compare("out_bytes", 32'(want.out_bytes), 32'(got.out_bytes));
        compare("out_offset", want.out_offset, got.out_offset);
        compare("data_valid", 32'(want.data_valid), 32'(got.data_valid));
        compare("done_res", 32'(want.done_res), 32'(got.done_res));
        compare("crc_value", want.crc_value, got.crc_value);
        compare("length_error", 32'(want.length_error), 32'(got.length_error));
        if (want.data_valid) data_results++;
        if (want.done_res) files_closed++;
        if (want.length_error) error_closes++;
    endfunction
endclass

module delta_prefilter_with_crc32_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1950;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 4;   // results are registered once; extra settle time

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_index = CFG_IDX_MODE;
    logic [31:0]       cfg_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [7:0]        s_in_byte = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [VAL_W-1:0]  m_out_value;
    logic [NB_W-1:0]   m_out_bytes;
    logic [OFF_W-1:0]  m_out_offset;
    logic              m_data_valid;
    logic              m_done_res;
    logic [31:0]       m_crc_value;
    logic              m_length_error;

    int unsigned src_idle_pct = 26;
    int unsigned sink_stall_pct = 48;
    int          bytes_sent = 0;
    int          files_sent = 0;

    filtered_stream_board tracker = new();

    delta_prefilter_with_crc32_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_value   (m_out_value),
        .m_out_bytes   (m_out_bytes),
        .m_out_offset  (m_out_offset),
        .m_data_valid  (m_data_valid),
        .m_done_res    (m_done_res),
        .m_crc_value   (m_crc_value),
        .m_length_error(m_length_error)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Receiver: random back-pressure, drawn fresh every cycle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Monitor: values read here are the ones present at the edge.
    // Results are checked before the same edge's byte is noted, since
    // a result can never belong to a byte accepted at that very edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                tracker.check_result('{out_value: m_out_value, out_bytes: m_out_bytes,
                                       out_offset: m_out_offset, data_valid: m_data_valid,
                                       done_res: m_done_res, crc_value: m_crc_value,
                                       length_error: m_length_error});
            end
            if (s_valid && s_ready) tracker.note_byte(s_in_byte);
            if (cfg_valid && cfg_ready) tracker.set_reg(cfg_index, cfg_data);
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("RESULT: ERROR");
        $finish;
    end

    // All driving tasks start and end on a rising edge.

    // Writes mode, then length, as two back-to-back config transfers.
    // Upper mode bits carry noise; only the low two are meaningful.
    task automatic configure(input logic [1:0] m, input logic [31:0] len);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IDX_MODE;
        cfg_data  <= {30'($urandom()), m};
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_IDX_LENGTH;
        cfg_data  <= len;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // One byte transfer, preceded by a random number of idle cycles.
    // Valid stays up between back-to-back bytes.
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    // Sender holds off until every predicted result has been seen,
    // then lets the pipeline settle.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom());
        endcase
    endfunction

    task automatic push_bytes(input int n);
        for (int i = 0; i < n; i++) push_byte(pick_byte());
    endtask

    // Mostly short files; a few long ones. Broken lengths either fall
    // inside the header or leave a partial word at the end.
    function automatic int unsigned file_length(input logic [1:0] m, input bit well_formed);
        int unsigned step;
        int unsigned k;
        step = (m == MODE_DELTA16) ? 2 : 4;
        k = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 120) : $urandom_range(0, 18);
        if (m == MODE_COPY) return $urandom_range(1, 120);
        if (well_formed) return HEADER_BYTES + step * k;
        if ($urandom_range(0, 1) == 1) return $urandom_range(1, HEADER_BYTES - 1);
        return HEADER_BYTES + step * k + $urandom_range(1, step - 1);
    endfunction

    // Full file at the given settings; occasionally pauses mid-file
    // until the output side has caught up.
    task automatic run_file(input logic [1:0] m, input int unsigned len);
        int pause_at;
        pause_at = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, len - 1)) : -1;
        configure(m, len);
        for (int i = 0; i < int'(len); i++) begin
            push_byte(pick_byte());
            if (i == pause_at) drain();
        end
        drain();
        files_sent++;
    endtask

    initial begin
        logic [1:0]  m;
        bit          well_formed;
        int          phase;
        int          file_idx;

        file_idx = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: single-byte and two-byte copy files
        configure(MODE_COPY, 32'd1);
        push_byte(8'hFF);
        drain();
        configure(MODE_COPY, 32'd2);
        push_byte(8'h00);
        push_byte(8'hA5);
        drain();

        // Directed: lengths shorter than the header, every delta mode;
        // only the final byte answers, flagging the error
        configure(MODE_DELTA16, 32'd3);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'h80);
        drain();
        configure(MODE_DELTA32, 32'd5);
        push_bytes(5);
        drain();
        configure(MODE_DEINT16, 32'd2);
        push_byte(8'h01);
        push_byte(8'hFE);
        drain();

        // Directed: all-ones length, then the length is cut short mid-file
        configure(MODE_COPY, 32'hFFFF_FFFF);
        push_bytes(3);
        drain();
        configure(MODE_COPY, tracker.pos + 32'd2);
        push_bytes(2);
        drain();

        // Directed: zero length never closes a file; silent in delta mode
        // until a real length is written mid-file
        configure(MODE_DELTA16, 32'd0);
        push_bytes(3);
        drain();
        configure(MODE_DELTA16, tracker.pos + 32'd2);
        push_bytes(2);
        drain();
        files_sent += 7;

        // Random files. First four cover each mode with a clean length.
        while (bytes_sent < ITEM_TARGET) begin
            phase = bytes_sent * 3 / ITEM_TARGET;
            case (phase)
                0: begin
                    src_idle_pct   = 26;
                    sink_stall_pct = 48;
                end
                1: begin
                    src_idle_pct   = 48;
                    sink_stall_pct = 26;
                end
                default: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
            endcase
            m = (file_idx < 4) ? 2'(file_idx) : 2'($urandom_range(0, 3));
            well_formed = (file_idx < 4) || ($urandom_range(0, 99) < 80);
            run_file(m, file_length(m, well_formed));
            file_idx++;
        end

        drain();
        $display("Covered %0d byte transfers over %0d files in all four filter modes.",
                 bytes_sent, files_sent);
        $display("Checked %0d data results, %0d file ends, %0d of them length errors.",
                 tracker.data_results, tracker.files_closed, tracker.error_closes);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
